@@ hdl/rfa_pkg.sv @@
// Package for the rational fraction ALU: operation codes and the mode type.
// Used by rational_fraction_alu_core.
package rfa_pkg;
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_ADD = 2'd2;
  localparam logic [1:0] OP_SUB = 2'd3;
  typedef logic [1:0] mode_t;
endpackage

@@ hdl/rfa_divider.sv @@
// Restoring radix-2 unsigned divider, one quotient bit per cycle while busy.
// Depends on nothing but its parameter.
module rfa_divider #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] quo;
  logic [W-1:0] rem;
  logic [W-1:0] dsr;
  logic [CW-1:0] count;
  logic busy;
  logic [W:0] trial;

  assign trial = {rem, quo[W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(W);
        quo <= dividend;
        rem <= '0;
        dsr <= divisor;
      end else if (busy) begin
        if (trial[W]) begin
          rem <= {rem[W-2:0], quo[W-1]};
          quo <= {quo[W-2:0], 1'b0};
        end else begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
  assign remainder = rem;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy && !start |=> busy || done) else $error("divider dropped work");
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> count == '0 || $past(start) == 1'b0) else $error("count state");
endmodule

@@ hdl/rational_fraction_alu_core.sv @@
// Rational fraction ALU top level: products, Euclidean GCD, final reduction.
// Depends on rfa_pkg and rfa_divider.
//
// Usage: in channel (in_valid/in_ready) takes mode and two signed fractions;
// out channel (out_valid/out_ready) returns the reduced numerator and
// denominator plus undefined_error. One item is processed at a time: in_ready
// is high only when the block is idle and no result is pending.
// Sequence: three products on one shared multiplier, loading the GCD pair,
// then one divider pass per Euclid step, leaving the loop, two more passes
// for the final divisions and raising out_valid. The radix-2 divider is
// shared by all passes (W = 2*OPERAND_BITS+1), so the time from accept to
// out_valid grows with the number of steps, which is data dependent (none
// when the raw numerator is zero, at most about 47). A zero/zero item skips
// the divider and goes from loading the GCD pair straight to out_valid.
// A new item can be taken in the cycle after the result is delivered.
// Signs are not normalized: the denominator may come out negative.
// If both raw values are zero the result is 0/0 with undefined_error set.
// Reset (rst, synchronous) returns to idle and drops any pending result.
// A stalled receiver holds the result in the output register; no new item
// is taken until it is delivered.
module rational_fraction_alu_core #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rfa_pkg::mode_t                mode,
  input  logic signed [OPERAND_BITS-1:0] a_numerator,
  input  logic signed [OPERAND_BITS-1:0] a_denominator,
  input  logic signed [OPERAND_BITS-1:0] b_numerator,
  input  logic signed [OPERAND_BITS-1:0] b_denominator,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [2*OPERAND_BITS:0] result_numerator,
  output logic signed [2*OPERAND_BITS:0] result_denominator,
  output logic                          undefined_error
);
  import rfa_pkg::*;

  localparam int OB = OPERAND_BITS;
  localparam int PB = 2 * OB;
  localparam int RB = 2 * OB + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL2 = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIVN = 3'd4;
  localparam logic [2:0] S_DIVD = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_MUL1 = 3'd7;

  logic [2:0] state;
  logic started;
  mode_t op;
  logic signed [OB-1:0] an, ad, bn, bd;
  logic signed [PB-1:0] p1, p2;
  logic signed [RB-1:0] n, d;
  logic [RB-1:0] gx, gy;

  logic dv_start, dv_done;
  logic [RB-1:0] dv_a, dv_b, dv_q, dv_r;
  logic [RB-1:0] n_mag, d_mag;
  logic signed [OB-1:0] mul_x, mul_y;
  logic signed [PB-1:0] prod;

  rfa_divider #(.W(RB)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quotient(dv_q), .remainder(dv_r)
  );

  assign n_mag = n[RB-1] ? RB'(-n) : RB'(n);
  assign d_mag = d[RB-1] ? RB'(-d) : RB'(d);

  // one multiplier, three passes: an*x, ad*y, then ad*bd
  always_comb begin
    unique case (state)
      S_MUL1: begin
        mul_x = an;
        mul_y = (op == OP_MUL) ? bn : bd;
      end
      S_MUL2: begin
        mul_x = ad;
        mul_y = (op == OP_MUL) ? bd : bn;
      end
      default: begin
        mul_x = ad;
        mul_y = bd;
      end
    endcase
    prod = mul_x * mul_y;
  end

  always_comb begin
    dv_start = 1'b0;
    dv_a = gx;
    dv_b = gy;
    if (!started) begin
      unique case (state)
        S_GCD:   dv_start = (gy != '0);
        S_DIVN:  begin dv_start = 1'b1; dv_a = n_mag; dv_b = gx; end
        S_DIVD:  begin dv_start = 1'b1; dv_a = d_mag; dv_b = gx; end
        default: dv_start = 1'b0;
      endcase
    end
  end

  // result registers are only rewritten once the previous item is delivered
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      started <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= mode;
            an <= a_numerator;
            ad <= a_denominator;
            bn <= b_numerator;
            bd <= b_denominator;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          // p1 = an*x
          p1 <= prod;
          state <= S_MUL2;
        end
        S_MUL2: begin
          // p2 = ad*y
          p2 <= prod;
          state <= S_SUM;
        end
        S_SUM: begin
          d <= (op == OP_MUL || op == OP_DIV) ? RB'(p2) : RB'(prod);
          if (op == OP_ADD) n <= RB'(p1) + RB'(p2);
          else if (op == OP_SUB) n <= RB'(p1) - RB'(p2);
          else n <= RB'(p1);
          state <= S_GCD;
          started <= 1'b0;
          gx <= '0;
          gy <= '0;
        end
        S_GCD: begin
          if (gx == '0 && gy == '0 && !started) begin
            gx <= d_mag;
            gy <= n_mag;
            if (d_mag == '0 && n_mag == '0) begin
              result_numerator <= '0;
              result_denominator <= '0;
              undefined_error <= 1'b1;
              state <= S_OUT;
            end else if (n_mag == '0) begin
              started <= 1'b0;
            end
          end else if (!started) begin
            if (gy == '0) state <= S_DIVN;
            else started <= 1'b1;
          end else if (dv_done) begin
            gx <= gy;
            gy <= dv_r;
            started <= 1'b0;
          end
        end
        S_DIVN: begin
          if (!started) started <= 1'b1;
          else if (dv_done) begin
            result_numerator <= n[RB-1] ? -dv_q : dv_q;
            started <= 1'b0;
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (!started) started <= 1'b1;
          else if (dv_done) begin
            result_denominator <= d[RB-1] ? -dv_q : dv_q;
            undefined_error <= 1'b0;
            started <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && undefined_error |-> result_numerator == '0
      && result_denominator == '0) else $error("error result not zero");
  a_start_only_working: assert property (@(posedge clk) disable iff (rst)
    dv_start |-> state == S_GCD || state == S_DIVN || state == S_DIVD)
    else $error("divider start outside work");
endmodule
